### rtl/core/hsv_to_rgb565_core_macros.svh
// Assertion macros for the HSV to RGB565 converter checker.
// Expect clk and arst_n to be visible where the macros are used.
`ifndef HSV_TO_RGB565_CORE_MACROS_SVH
`define HSV_TO_RGB565_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define HSV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv565 check failed");

// next-cycle implication, disabled in reset
`define HSV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv565 check failed");

`endif

### rtl/core/hsv565_pkg.sv
// Shared constants and helpers for the HSV to RGB565 converter.
// No dependencies.
`timescale 1ns / 1ps

package hsv565_pkg;

	localparam logic [7:0]  HUE_STEPS   = 8'd255;
	localparam logic [15:0] FULL_SQ     = 16'd65025;
	localparam logic [7:0]  GREEN_SCALE = 8'd225;

	localparam logic [10:0] SIX_B1 = 11'd255;
	localparam logic [10:0] SIX_B2 = 11'd510;
	localparam logic [10:0] SIX_B3 = 11'd765;
	localparam logic [10:0] SIX_B4 = 11'd1020;
	localparam logic [10:0] SIX_B5 = 11'd1275;

	localparam logic [2:0] SEC_RED_UP    = 3'd0;
	localparam logic [2:0] SEC_RED_DOWN  = 3'd1;
	localparam logic [2:0] SEC_BLUE_UP   = 3'd2;
	localparam logic [2:0] SEC_GREEN_DN  = 3'd3;
	localparam logic [2:0] SEC_RED_RISE  = 3'd4;
	localparam logic [2:0] SEC_BLUE_DN   = 3'd5;

	// exact floor(x / 255) for x up to 65279
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

endpackage

### rtl/core/hsv_to_rgb565_core.sv
// HSV to RGB888 / RGB565 converter, eight-stage pipeline.
// Depends on hsv565_pkg.
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// hsv       in   hsv_valid/hsv_ready    hue, saturation, brightness
// rgb       out  rgb_valid/rgb_ready    red, green, blue, packed_565
//
// One transaction per clock sustained while rgb_ready holds; each passes through every stage register.
// Latency is set by the q/t lanes: multiply, reciprocal estimate, correction, final divide.
// Each full stage holds while the one after it is full and stalled; bubbles collapse.
// Reset clears the valid bits only.

module hsv_to_rgb565_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hsv_valid,
	output logic        hsv_ready,
	input  logic [7:0]  hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        rgb_valid,
	input  logic        rgb_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] packed_565
);
	import hsv565_pkg::*;

	localparam int NSTG = 8;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] adv;
	logic [NSTG:1]   vin;

	always_comb begin
		adv[NSTG+1] = rgb_ready;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		vin[1] = hsv_valid;
		for (int k = 2; k <= NSTG; k++) begin
			vin[k] = vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign hsv_ready = adv[1];
	assign rgb_valid = vld_q[NSTG];

	// stage 1: sector, fraction, p numerator
	logic [7:0]  hue_w;
	logic [10:0] six;
	logic [2:0]  sec_w;
	logic [10:0] frac_w;

	always_comb begin
		hue_w = (hue == HUE_STEPS) ? 8'd0 : hue;
		six   = ({3'b0, hue_w} << 2) + ({3'b0, hue_w} << 1);
		if (six >= SIX_B5) begin
			sec_w  = SEC_BLUE_DN;
			frac_w = six - SIX_B5;
		end else if (six >= SIX_B4) begin
			sec_w  = SEC_RED_RISE;
			frac_w = six - SIX_B4;
		end else if (six >= SIX_B3) begin
			sec_w  = SEC_GREEN_DN;
			frac_w = six - SIX_B3;
		end else if (six >= SIX_B2) begin
			sec_w  = SEC_BLUE_UP;
			frac_w = six - SIX_B2;
		end else if (six >= SIX_B1) begin
			sec_w  = SEC_RED_DOWN;
			frac_w = six - SIX_B1;
		end else begin
			sec_w  = SEC_RED_UP;
			frac_w = six;
		end
	end

	logic [2:0]  sec_s1, sec_s2, sec_s3, sec_s4, sec_s5, sec_s6;
	logic [7:0]  f_s1, sat_s1;
	logic [7:0]  val_s1, val_s2, val_s3, val_s4, val_s5, val_s6;
	logic [15:0] pn_s1;
	logic [7:0]  p_s2, p_s3, p_s4, p_s5, p_s6;
	logic [15:0] sf_s2, st_s2;
	logic [23:0] qx_s3, tx_s3, qx_s4, tx_s4;
	logic [15:0] qe_s4, te_s4, qa_s5, ta_s5;
	logic [7:0]  q_s6, t_s6;
	logic [7:0]  r_s7, g_s7, b_s7;
	logic [15:0] gp_s7;
	logic [7:0]  red_s8, green_s8, blue_s8;
	logic [15:0] pk_s8;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sec_s1 <= sec_w;
			f_s1   <= frac_w[7:0];
			sat_s1 <= saturation;
			val_s1 <= brightness;
			pn_s1  <= {8'b0, brightness} * {8'b0, HUE_STEPS - saturation};
		end
	end

	// stage 2: p, saturation products
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sec_s2 <= sec_s1;
			val_s2 <= val_s1;
			p_s2   <= div255(pn_s1);
			sf_s2  <= {8'b0, sat_s1} * {8'b0, f_s1};
			st_s2  <= {8'b0, sat_s1} * {8'b0, HUE_STEPS - f_s1};
		end
	end

	// stage 3: value products
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sec_s3 <= sec_s2;
			val_s3 <= val_s2;
			p_s3   <= p_s2;
			qx_s3  <= {16'b0, val_s2} * {8'b0, FULL_SQ - sf_s2};
			tx_s3  <= {16'b0, val_s2} * {8'b0, FULL_SQ - st_s2};
		end
	end

	// stage 4: x/255 estimate as x*257 >> 16, never above the true quotient
	logic [32:0] qm, tm;

	always_comb begin
		qm = {9'b0, qx_s3} + {1'b0, qx_s3, 8'b0};
		tm = {9'b0, tx_s3} + {1'b0, tx_s3, 8'b0};
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			sec_s4 <= sec_s3;
			val_s4 <= val_s3;
			p_s4   <= p_s3;
			qx_s4  <= qx_s3;
			tx_s4  <= tx_s3;
			qe_s4  <= qm[31:16];
			te_s4  <= tm[31:16];
		end
	end

	// stage 5: correct the estimate by one
	logic [23:0] qrem, trem;

	always_comb begin
		qrem = qx_s4 - (({8'b0, qe_s4} << 8) - {8'b0, qe_s4});
		trem = tx_s4 - (({8'b0, te_s4} << 8) - {8'b0, te_s4});
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			sec_s5 <= sec_s4;
			val_s5 <= val_s4;
			p_s5   <= p_s4;
			qa_s5  <= (qrem >= {16'b0, HUE_STEPS}) ? qe_s4 + 16'd1 : qe_s4;
			ta_s5  <= (trem >= {16'b0, HUE_STEPS}) ? te_s4 + 16'd1 : te_s4;
		end
	end

	// stage 6: second divide by 255
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			sec_s6 <= sec_s5;
			val_s6 <= val_s5;
			p_s6   <= p_s5;
			q_s6   <= div255(qa_s5);
			t_s6   <= div255(ta_s5);
		end
	end

	// stage 7: sector assignment, green product
	logic [7:0] r_w, g_w, b_w;

	always_comb begin
		case (sec_s6)
			SEC_RED_UP: begin
				r_w = val_s6; g_w = t_s6;   b_w = p_s6;
			end
			SEC_RED_DOWN: begin
				r_w = q_s6;   g_w = val_s6; b_w = p_s6;
			end
			SEC_BLUE_UP: begin
				r_w = p_s6;   g_w = val_s6; b_w = t_s6;
			end
			SEC_GREEN_DN: begin
				r_w = p_s6;   g_w = q_s6;   b_w = val_s6;
			end
			SEC_RED_RISE: begin
				r_w = t_s6;   g_w = p_s6;   b_w = val_s6;
			end
			default: begin
				r_w = val_s6; g_w = p_s6;   b_w = q_s6;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			r_s7  <= r_w;
			g_s7  <= g_w;
			b_s7  <= b_w;
			gp_s7 <= {8'b0, g_w} * {8'b0, GREEN_SCALE};
		end
	end

	// stage 8: green scaling, pack, output register
	logic [7:0] gs_w;

	assign gs_w = div255(gp_s7);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			red_s8   <= r_s7;
			green_s8 <= gs_w;
			blue_s8  <= b_s7;
			pk_s8    <= {r_s7[7:3], gs_w[7:2], b_s7[7:3]};
		end
	end

	assign red        = red_s8;
	assign green      = green_s8;
	assign blue       = blue_s8;
	assign packed_565 = pk_s8;

endmodule

### rtl/core/hsv565_checker.sv
// Port-level checker for hsv_to_rgb565_core, bound into hsv_to_rgb565_core.
// Depends on hsv_to_rgb565_core_macros.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb565_core_macros.svh"

module hsv565_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        hsv_valid,
	input logic        hsv_ready,
	input logic [7:0]  hue,
	input logic [7:0]  saturation,
	input logic [7:0]  brightness,
	input logic        rgb_valid,
	input logic        rgb_ready,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [15:0] packed_565
);

	`HSV_ASSERT_NEXT(a_out_hold, rgb_valid && !rgb_ready, rgb_valid)
	`HSV_ASSERT_NEXT(a_out_stable, rgb_valid && !rgb_ready, $stable(packed_565) && $stable(red))
	`HSV_ASSERT_NOW(a_green_range, rgb_valid, green <= 8'd225)
	`HSV_ASSERT_NOW(a_pack, rgb_valid, packed_565 == {red[7:3], green[7:2], blue[7:3]})

endmodule

bind hsv_to_rgb565_core hsv565_checker u_hsv565_checker (.*);

### tb/sv/tb_top.sv
// Self-checking bench for hsv_to_rgb565_core: a table of directed colours, then random HSV
// triples, under random idling on both handshakes, each result compared with a table entry or a local model.
// Depends on hsv565_pkg and hsv_to_rgb565_core.
`timescale 1ns / 1ps

module tb_top;
	import hsv565_pkg::*;

	localparam int unsigned RANDOM_PIXELS = 700;
	localparam int unsigned DRAIN_AT      = 350;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] packed_565;
	} rgb_pixel_t;

	typedef struct packed {
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
		logic       typed;
		rgb_pixel_t want;
	} colour_row_t;

	localparam rgb_pixel_t BLACK    = '{8'd0, 8'd0, 8'd0, 16'h0000};
	localparam rgb_pixel_t PURE_RED = '{8'd255, 8'd0, 8'd0, 16'hF800};
	localparam rgb_pixel_t WHITE    = '{8'd255, 8'd225, 8'd255, 16'hFF1F};
	localparam int unsigned N_ROWS  = 24;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        hsv_valid  = 1'b0;
	logic        hsv_ready;
	logic [7:0]  hue        = 8'd0;
	logic [7:0]  saturation = 8'd0;
	logic [7:0]  brightness = 8'd0;
	logic        rgb_valid;
	logic        rgb_ready  = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] packed_565;

	rgb_pixel_t  pending_colours[$];
	int unsigned pixels_in   = 0;
	int unsigned pixels_out  = 0;
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          no_idle     = 1'b0;

	colour_row_t colour_table [N_ROWS] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, BLACK},
		'{8'd0,   8'd255, 8'd255, 1'b1, PURE_RED},
		'{8'd255, 8'd255, 8'd255, 1'b1, PURE_RED},
		'{8'd0,   8'd0,   8'd255, 1'b1, WHITE},
		'{8'd128, 8'd0,   8'd255, 1'b1, WHITE},
		'{8'd200, 8'd255, 8'd0,   1'b1, BLACK},
		'{8'd255, 8'd0,   8'd0,   1'b1, BLACK},
		'{8'd42,  8'd255, 8'd255, 1'b0, BLACK},
		'{8'd43,  8'd255, 8'd255, 1'b0, BLACK},
		'{8'd84,  8'd255, 8'd255, 1'b0, BLACK},
		'{8'd85,  8'd255, 8'd255, 1'b0, BLACK},
		'{8'd127, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd128, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd169, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd170, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd212, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd213, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd254, 8'd255, 8'd255, 1'b0, BLACK},
		'{8'd254, 8'd1,   8'd255, 1'b0, BLACK},
		'{8'd20,  8'd128, 8'd200, 1'b0, BLACK},
		'{8'd100, 8'd170, 8'd90,  1'b0, BLACK},
		'{8'd150, 8'd64,  8'd1,   1'b0, BLACK},
		'{8'd170, 8'd85,  8'd170, 1'b0, BLACK},
		'{8'd85,  8'd170, 8'd85,  1'b0, BLACK}
	};

	hsv_to_rgb565_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.packed_565 (packed_565)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rgb_pixel_t hsv_convert(input logic [7:0] h, input logic [7:0] s,
			input logic [7:0] v);
		int unsigned angle, sat, val, six, frac, lo, fall, rise, r, g, b, gs;
		logic [2:0]  sector;
		rgb_pixel_t  px;
		angle  = (h == HUE_STEPS) ? 0 : h;
		sat    = s;
		val    = v;
		six    = angle * 6;
		sector = 3'(six / HUE_STEPS);
		frac   = six % HUE_STEPS;
		lo     = val * (HUE_STEPS - sat) / HUE_STEPS;
		fall   = val * (FULL_SQ - sat * frac) / FULL_SQ;
		rise   = val * (FULL_SQ - sat * (HUE_STEPS - frac)) / FULL_SQ;
		case (sector)
			SEC_RED_UP: begin
				r = val;  g = rise; b = lo;
			end
			SEC_RED_DOWN: begin
				r = fall; g = val;  b = lo;
			end
			SEC_BLUE_UP: begin
				r = lo;   g = val;  b = rise;
			end
			SEC_GREEN_DN: begin
				r = lo;   g = fall; b = val;
			end
			SEC_RED_RISE: begin
				r = rise; g = lo;   b = val;
			end
			default: begin
				r = val;  g = lo;   b = fall;
			end
		endcase
		gs = g * GREEN_SCALE / HUE_STEPS;
		px.red        = r[7:0];
		px.green      = gs[7:0];
		px.blue       = b[7:0];
		px.packed_565 = {px.red[7:3], px.green[7:2], px.blue[7:3]};
		return px;
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// hold valid across back-to-back transactions; lower it only where a gap follows
	task automatic send_colour(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
			input logic typed, input rgb_pixel_t want, input bit drain);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (drain && gap == 0)
			gap = 1;
		if (gap != 0) begin
			hsv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && pending_colours.size() != 0) @(posedge clk);
		end
		hsv_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		@(posedge clk);
		while (!hsv_ready) @(posedge clk);
		pending_colours.push_back(typed ? want : hsv_convert(h, s, v));
		pixels_in++;
	endtask

	task automatic compare_colour(input rgb_pixel_t got);
		rgb_pixel_t want;
		if (pending_colours.size() == 0) begin
			$display("%0t: unexpected result red %0d green %0d blue %0d packed %h",
				$time, got.red, got.green, got.blue, got.packed_565);
			mismatches++;
		end else begin
			want = pending_colours.pop_front();
			if (got.red !== want.red) begin
				$display("%0t: red expected %0d got %0d", $time, want.red, got.red);
				mismatches++;
			end
			if (got.green !== want.green) begin
				$display("%0t: green expected %0d got %0d", $time, want.green, got.green);
				mismatches++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
				mismatches++;
			end
			if (got.packed_565 !== want.packed_565) begin
				$display("%0t: packed_565 expected %h got %h", $time, want.packed_565,
					got.packed_565);
				mismatches++;
			end
		end
	endtask

	// sink side: random stall before each transaction, none while no_idle holds
	initial begin
		int unsigned stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rgb_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb_ready <= 1'b1;
			@(posedge clk);
			while (!rgb_valid) @(posedge clk);
			compare_colour('{red, green, blue, packed_565});
			pixels_out++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL hsv_to_rgb565_core");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			no_idle = (i >= 16);
			send_colour(colour_table[i].h, colour_table[i].s, colour_table[i].v,
				colour_table[i].typed, colour_table[i].want, 1'b0);
		end

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			no_idle = ((i % 160) >= 120);
			send_colour(pick_level(), pick_level(), pick_level(), 1'b0, BLACK,
				i == DRAIN_AT);
		end
		hsv_valid <= 1'b0;

		while (pending_colours.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Converted %0d colours (%0d directed, %0d random) with %0d results seen,",
			pixels_in, N_ROWS, RANDOM_PIXELS, pixels_out);
		$display("all six hue sectors, hue wrap, grey and black, under random idling: %0d errors",
			mismatches);
		if (mismatches == 0)
			$display("PASS hsv_to_rgb565_core");
		else
			$display("FAIL hsv_to_rgb565_core");
		$finish;
	end

endmodule

### hsv_to_rgb565_core.f
+incdir+rtl/core
rtl/core/hsv565_pkg.sv
rtl/core/hsv_to_rgb565_core.sv
rtl/core/hsv565_checker.sv
tb/sv/tb_top.sv
